### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the line grid intersection block.
// Depends on nothing; define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

### hdl/lgi_pkg.sv
// Types, codes and saturation helpers for the line grid intersection block.
// Depends on nothing.
package lgi_pkg;

  localparam int MAX_COLUMNS_DEF = 32;
  localparam int DIV_NW = 50;
  localparam int DIV_DW = 34;
  localparam int MUL_W = 32;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_COLUMN = 2'd1;
  localparam logic [1:0] FUNC_ROW    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_DIV, ST_DIVD, ST_MUL, ST_SUM, ST_FIN, ST_COL, ST_EMIT
  } state_t;

  function automatic logic [31:0] abs32(logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [63:0] abs64(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [31:0] sat32(logic neg, logic [63:0] q);
    logic signed [31:0] r;
    if (!neg) begin
      r = (q > 64'd2147483647) ? 32'sh7FFFFFFF : $signed(q[31:0]);
    end else begin
      r = (q > 64'd2147483648) ? 32'sh80000000 : -$signed(q[31:0]);
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(logic neg, logic [32:0] q);
    logic signed [15:0] r;
    if (!neg) begin
      r = (q > 33'd32767) ? 16'sh7FFF : $signed(q[15:0]);
    end else begin
      r = (q > 33'd32768) ? 16'sh8000 : -$signed(q[15:0]);
    end
    return r;
  endfunction

endpackage

### hdl/line_grid_intersection.sv
// Line grid intersection: column table plus bit-serial divider and multiplier.
// Clear or vertical column: done in decode; add column: 50-step divide, then 32-step multiply.
// Row: divide and multiply for the row line (none if vertical), then per column a divide and
// multiply, a multiply if vertical, none if degenerate, plus output stalls; one word per column.
// One item at a time: input held off until it finishes, for a row until its last word is taken.
// Synchronous active-low reset empties the column table; entries hold no reset.
`include "assert_macros.svh"
module line_grid_intersection #(
  parameter int MAX_COLUMNS = lgi_pkg::MAX_COLUMNS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic signed [15:0] in_first_x,
  input  logic signed [15:0] in_first_y,
  input  logic signed [15:0] in_second_x,
  input  logic signed [15:0] in_second_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_grid_x,
  output logic signed [15:0] out_grid_y,
  output logic [5:0]         out_column_index,
  output logic               out_degenerate,
  output logic               out_last
);
  import lgi_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int IW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r;
  logic [IW-1:0] idx_r;
  logic out_valid_r;
  logic [1:0] func_r;
  logic signed [15:0] x1_r, y1_r, x2_r, y2_r;
  logic row_vert_r, is_col_r;

  logic signed [31:0] slope_mem [MAX_COLUMNS];
  logic signed [31:0] icpt_mem [MAX_COLUMNS];
  logic               vert_mem [MAX_COLUMNS];
  logic signed [15:0] topx_mem [MAX_COLUMNS];

  logic [DIV_NW-1:0] dn_r;
  logic [DIV_DW-1:0] drem_r;
  logic [DIV_DW-1:0] dd_r;
  logic              dneg_r;
  logic [5:0]        dcnt_r;

  logic [MUL_W-1:0]   ma_r, mb_r;
  logic [2*MUL_W-1:0] macc_r;
  logic               mneg_r;
  logic [4:0]         mcnt_r;

  logic signed [31:0] mm_r, mr_r, br_r, xq_r, cola_r, colb_r;
  logic signed [63:0] sum_r;
  logic signed [15:0] gx_r, gy_r;
  logic [5:0] cidx_r;
  logic degen_r, last_r;

  logic in_fire, out_fire;
  logic signed [31:0] rd_slope, rd_icpt;
  logic rd_vert;
  logic signed [15:0] rd_topx;
  logic col_degen, last_w, tbl_full, mem_we;
  logic signed [16:0] dx_w, dy_w;
  logic div_ld, mul_ld;
  logic signed [DIV_NW-1:0] div_num;
  logic signed [DIV_DW-1:0] div_den;
  logic [DIV_NW-1:0] num_mag;
  logic [DIV_DW-1:0] den_mag;
  logic [DIV_DW:0] rem_sh;
  logic rem_ge;
  logic signed [31:0] q_sat, mul_a, mul_b, b_w, topx_q;
  logic [MUL_W:0] msum_w;
  logic signed [63:0] prod_w;
  logic signed [31:0] wr_slope, wr_icpt;
  logic wr_vert;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_grid_x = gx_r;
  assign out_grid_y = gy_r;
  assign out_column_index = cidx_r;
  assign out_degenerate = degen_r;
  assign out_last = last_r;

  assign rd_slope = slope_mem[idx_r];
  assign rd_icpt  = icpt_mem[idx_r];
  assign rd_vert  = vert_mem[idx_r];
  assign rd_topx  = topx_mem[idx_r];
  assign topx_q   = 32'(rd_topx) <<< 12;

  assign col_degen = row_vert_r || (!rd_vert && (rd_slope == mr_r));
  assign last_w = ((CW'(idx_r) + CW'(1)) == count_r);
  assign tbl_full = (count_r >= CW'(MAX_COLUMNS));
  assign dx_w = 17'(x2_r) - 17'(x1_r);
  assign dy_w = 17'(y2_r) - 17'(y1_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_DECODE;
      ST_DECODE: begin
        priority case (func_r)
          FUNC_COLUMN: state_nxt = (tbl_full || x1_r == x2_r) ? ST_IDLE : ST_DIV;
          FUNC_ROW: begin
            if (count_r == '0) state_nxt = ST_IDLE;
            else if (x1_r == x2_r) state_nxt = ST_COL;
            else state_nxt = ST_DIV;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_DIV: if (dcnt_r == 6'(DIV_NW - 1)) state_nxt = ST_DIVD;
      ST_DIVD: state_nxt = ST_MUL;
      ST_MUL: if (mcnt_r == 5'(MUL_W - 1)) state_nxt = ST_SUM;
      ST_SUM: state_nxt = ST_FIN;
      ST_FIN: begin
        if (is_col_r) state_nxt = ST_EMIT;
        else if (func_r == FUNC_ROW) state_nxt = ST_COL;
        else state_nxt = ST_IDLE;
      end
      ST_COL: begin
        if (col_degen) state_nxt = ST_EMIT;
        else if (rd_vert) state_nxt = ST_MUL;
        else state_nxt = ST_DIV;
      end
      ST_EMIT: if (out_ready) state_nxt = last_r ? ST_IDLE : ST_COL;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    div_ld = (state_nxt == ST_DIV) && (state_r == ST_DECODE || state_r == ST_COL);
    if (state_r == ST_COL) begin
      div_num = (50'(br_r) - 50'(rd_icpt)) <<< 16;
      div_den = 34'(rd_slope) - 34'(mr_r);
    end else begin
      div_num = 50'(dy_w) <<< 16;
      div_den = 34'(dx_w);
    end
    num_mag = div_num[DIV_NW-1] ? DIV_NW'(-div_num) : DIV_NW'(div_num);
    den_mag = div_den[DIV_DW-1] ? DIV_DW'(-div_den) : DIV_DW'(div_den);
    rem_sh = {drem_r, dn_r[DIV_NW-1]};
    rem_ge = (rem_sh >= {1'b0, dd_r});
    q_sat = sat32(dneg_r, 64'(dn_r));

    mul_ld = (state_r == ST_DIVD) || (state_r == ST_COL && state_nxt == ST_MUL);
    if (state_r == ST_COL) begin
      mul_a = mr_r;
      mul_b = topx_q;
    end else if (is_col_r) begin
      mul_a = cola_r;
      mul_b = q_sat;
    end else begin
      mul_a = q_sat;
      mul_b = 32'(x1_r);
    end
    msum_w = {1'b0, macc_r[2*MUL_W-1:MUL_W]} + (mb_r[0] ? {1'b0, ma_r} : '0);
    prod_w = mneg_r ? -$signed(macc_r) : $signed(macc_r);
    b_w = sat32(sum_r[63], (abs64(sum_r) + 64'd8) >> 4);

    if (state_r == ST_DECODE) begin
      mem_we = (func_r == FUNC_COLUMN) && !tbl_full && (x1_r == x2_r);
      wr_slope = '0;
      wr_icpt = '0;
      wr_vert = 1'b1;
    end else begin
      mem_we = (state_r == ST_FIN) && !is_col_r && (func_r == FUNC_COLUMN);
      wr_slope = mm_r;
      wr_icpt = b_w;
      wr_vert = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DECODE && func_r == FUNC_CLEAR) count_r <= '0;
      else if (mem_we) count_r <= count_r + CW'(1);
      if (state_nxt == ST_EMIT && state_r != ST_EMIT) out_valid_r <= 1'b1;
      else if (out_fire) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slope_mem[count_r[IW-1:0]] <= wr_slope;
      icpt_mem[count_r[IW-1:0]] <= wr_icpt;
      vert_mem[count_r[IW-1:0]] <= wr_vert;
      topx_mem[count_r[IW-1:0]] <= x1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_func;
      x1_r <= in_first_x;
      y1_r <= in_first_y;
      x2_r <= in_second_x;
      y2_r <= in_second_y;
    end
    if (div_ld) begin
      dn_r <= num_mag + DIV_NW'(den_mag >> 1);
      drem_r <= '0;
      dd_r <= den_mag;
      dneg_r <= div_num[DIV_NW-1] ^ div_den[DIV_DW-1];
      dcnt_r <= '0;
    end else if (state_r == ST_DIV) begin
      drem_r <= rem_ge ? DIV_DW'(rem_sh - {1'b0, dd_r}) : rem_sh[DIV_DW-1:0];
      dn_r <= {dn_r[DIV_NW-2:0], rem_ge};
      dcnt_r <= dcnt_r + 6'd1;
    end
    if (mul_ld) begin
      ma_r <= abs32(mul_a);
      mb_r <= abs32(mul_b);
      macc_r <= '0;
      mneg_r <= mul_a[31] ^ mul_b[31];
      mcnt_r <= '0;
    end else if (state_r == ST_MUL) begin
      macc_r <= {msum_w, macc_r[MUL_W-1:1]};
      mb_r <= mb_r >> 1;
      mcnt_r <= mcnt_r + 5'd1;
    end
    unique case (state_r)
      ST_DECODE: begin
        row_vert_r <= (x1_r == x2_r);
        is_col_r <= 1'b0;
        idx_r <= '0;
      end
      ST_DIVD: begin
        if (is_col_r) xq_r <= q_sat;
        else mm_r <= q_sat;
      end
      ST_SUM: begin
        if (is_col_r) sum_r <= prod_w + (64'(colb_r) <<< 16);
        else sum_r <= (64'(y1_r) <<< 20) - prod_w;
      end
      ST_FIN: begin
        if (is_col_r) begin
          gx_r <= sat16(xq_r[31], 33'(({1'b0, abs32(xq_r)} + 33'd32768) >> 16));
          gy_r <= sat16(sum_r[63], {1'b0, 32'((abs64(sum_r) + 64'd2147483648) >> 32)});
          degen_r <= 1'b0;
          cidx_r <= 6'(idx_r);
          last_r <= last_w;
        end else begin
          mr_r <= mm_r;
          br_r <= b_w;
          idx_r <= '0;
        end
      end
      ST_COL: begin
        is_col_r <= 1'b1;
        if (col_degen) begin
          gx_r <= '0;
          gy_r <= '0;
          degen_r <= 1'b1;
          cidx_r <= 6'(idx_r);
          last_r <= last_w;
        end else if (rd_vert) begin
          xq_r <= topx_q;
          colb_r <= br_r;
        end else begin
          cola_r <= rd_slope;
          colb_r <= rd_icpt;
        end
      end
      ST_EMIT: if (out_ready && !last_r) idx_r <= idx_r + IW'(1);
      default: ;
    endcase
  end

  `ASSERT_ALWAYS(a_one_at_a_time, clk, rst_n, !(in_ready && out_valid), "word accepted while result pending")
  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CW'(MAX_COLUMNS), "column count overflow")
  `ASSERT_ALWAYS(a_degen_zero, clk, rst_n, !(out_valid && out_degenerate) || (out_grid_x == '0 && out_grid_y == '0), "degenerate word carries coordinates")
  `ASSERT_NEXT(a_last_idle, clk, rst_n, out_valid && out_ready && out_last, in_ready, "row did not end after last word")

endmodule
